@@ rtl/core/xrr_pkg.sv @@
// ----------------------------------------------------------------------------
// xrr_pkg: shared types and constants for the xorshift range generator
// Opcodes, controller state codes, command/status bundles, fixed constants.
// ----------------------------------------------------------------------------
package xrr_pkg;

  localparam int unsigned STATE_W   = 32;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned THR_W     = 8;
  localparam int unsigned DIV_STEPS = VALUE_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [STATE_W-1:0] ZERO_SUBST  = 32'h2545F491;
  localparam logic [VALUE_W-1:0] PERCENT_TOP = 16'd99;
  localparam int unsigned        SHIFT_A     = 13;
  localparam int unsigned        SHIFT_B     = 17;
  localparam int unsigned        SHIFT_C     = 5;
  localparam int unsigned        RAW_LSB     = 8;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_RANGE   = 2'd1,
    OP_PERCENT = 2'd2,
    OP_SEED    = 2'd3
  } xrr_op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } xrr_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic out_load;
  } xrr_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } xrr_sts_t;

endpackage

@@ rtl/core/xrr_in_if.sv @@
// ----------------------------------------------------------------------------
// xrr_in_if: request channel of the xorshift range generator
// Valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface xrr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] range_low;
  logic [15:0] range_high;
  logic [7:0]  percent_threshold;
  logic [31:0] seed_value;

  modport source (
    output valid, op, range_low, range_high, percent_threshold, seed_value,
    input  ready
  );
  modport sink (
    input  valid, op, range_low, range_high, percent_threshold, seed_value,
    output ready
  );
endinterface

@@ rtl/core/xrr_out_if.sv @@
// ----------------------------------------------------------------------------
// xrr_out_if: result channel of the xorshift range generator
// Valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface xrr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        hit;

  modport source (
    output valid, value, hit,
    input  ready
  );
  modport sink (
    input  valid, value, hit,
    output ready
  );
endinterface

@@ rtl/core/xrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// xrr_ctrl: sequencer of the xorshift range generator
// Steps one request through setup, the remainder loop and result hand-off.
// ----------------------------------------------------------------------------
module xrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  xrr_pkg::xrr_sts_t sts,
  output xrr_pkg::xrr_cmd_t cmd
);
  import xrr_pkg::*;

  xrr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/xrr_dp.sv @@
// ----------------------------------------------------------------------------
// xrr_dp: datapath of the xorshift range generator
// Generator state, xorshift step, restoring remainder unit, result register.
// ----------------------------------------------------------------------------
module xrr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  xrr_pkg::xrr_cmd_t cmd,
  output xrr_pkg::xrr_sts_t sts,
  input  logic [1:0]        in_op,
  input  logic [15:0]       in_range_low,
  input  logic [15:0]       in_range_high,
  input  logic [7:0]        in_percent_threshold,
  input  logic [31:0]       in_seed_value,
  output logic [15:0]       out_value,
  output logic              out_hit
);
  import xrr_pkg::*;

  logic [STATE_W-1:0] gen_r;
  xrr_op_t            op_r;
  logic [VALUE_W-1:0] lo_r, hi_r;
  logic [THR_W-1:0]   thr_r;
  logic [STATE_W-1:0] seed_r;
  logic [VALUE_W-1:0] dvd_r, span_r, rem_r, val_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_hit_r;

  logic [STATE_W-1:0] x0, x1, x2, x3;
  logic [VALUE_W-1:0] raw;
  logic               ranged;
  logic [VALUE_W-1:0] eff_lo, eff_hi, span_w;
  logic               empty;
  logic [VALUE_W:0]   shifted, diff;
  logic               ge;
  logic [VALUE_W-1:0] rem_nxt;

  assign x0  = (gen_r == '0) ? ZERO_SUBST : gen_r;
  assign x1  = x0 ^ (x0 << SHIFT_A);
  assign x2  = x1 ^ (x1 >> SHIFT_B);
  assign x3  = x2 ^ (x2 << SHIFT_C);
  assign raw = x3[RAW_LSB +: VALUE_W];

  assign ranged = (op_r == OP_RANGE) || (op_r == OP_PERCENT);
  assign eff_lo = (op_r == OP_PERCENT) ? '0 : lo_r;
  assign eff_hi = (op_r == OP_PERCENT) ? PERCENT_TOP : hi_r;
  assign empty  = (eff_hi <= eff_lo);
  assign span_w = VALUE_W'(eff_hi - eff_lo + VALUE_W'(1));

  assign sts.need_div = ranged && !empty && (span_w != '0);
  assign sts.div_last = (cnt_r == '0);

  assign shifted = {rem_r, dvd_r[VALUE_W-1]};
  assign diff    = shifted - {1'b0, span_r};
  assign ge      = (shifted >= {1'b0, span_r});
  assign rem_nxt = ge ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else if (cmd.prep) begin
      unique case (op_r)
        OP_SEED:               gen_r <= seed_r;
        OP_RAW:                gen_r <= x3;
        OP_RANGE, OP_PERCENT: begin
          if (!empty) begin
            gen_r <= x3;
          end
        end
        default:               gen_r <= gen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= xrr_op_t'(in_op);
      lo_r   <= in_range_low;
      hi_r   <= in_range_high;
      thr_r  <= in_percent_threshold;
      seed_r <= in_seed_value;
    end
    if (cmd.prep) begin
      unique case (op_r)
        OP_SEED: val_r <= '0;
        OP_RAW:  val_r <= raw;
        OP_RANGE, OP_PERCENT: begin
          val_r <= empty ? eff_lo : raw;
        end
        default: val_r <= '0;
      endcase
      dvd_r  <= raw;
      span_r <= span_w;
      rem_r  <= '0;
      cnt_r  <= CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[VALUE_W-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
      if (sts.div_last) begin
        val_r <= VALUE_W'(eff_lo + rem_nxt);
      end
    end
    if (cmd.out_load) begin
      out_value_r <= val_r;
      out_hit_r   <= (op_r == OP_PERCENT) && (val_r < {{(VALUE_W-THR_W){1'b0}}, thr_r});
    end
  end

  assign out_value = out_value_r;
  assign out_hit   = out_hit_r;

endmodule

@@ rtl/core/xorshift_random_range.sv @@
// ----------------------------------------------------------------------------
// xorshift_random_range: xorshift32 generator with range and percent draws
// Raw draw, range draw, percent test and seed load over valid/ready channels.
// ----------------------------------------------------------------------------
// One request is processed at a time. A raw draw, a seed load or an empty
// range passes accept, setup and hand-off to the result register; a range draw
// or percent test that needs a remainder also runs the one-bit-per-cycle
// restoring remainder loop (16 steps) before hand-off. The result register
// lets a new request be accepted while the previous result waits.
module xorshift_random_range (
  input  logic      clk,
  input  logic      rst_n,
  xrr_in_if.sink    in_ch,
  xrr_out_if.source out_ch
);
  import xrr_pkg::*;

  xrr_cmd_t cmd;
  xrr_sts_t sts;

  xrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  xrr_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_ch.op),
    .in_range_low         (in_ch.range_low),
    .in_range_high        (in_ch.range_high),
    .in_percent_threshold (in_ch.percent_threshold),
    .in_seed_value        (in_ch.seed_value),
    .out_value            (out_ch.value),
    .out_hit              (out_ch.hit)
  );

endmodule
